@@ sv/ftsc_pkg.sv @@
package ftsc_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    OP_TARGET = 2'd0,
    OP_EMPTY  = 2'd1,
    OP_REF    = 2'd2,
    OP_TICK   = 2'd3
  } ftsc_op_t;

  // Configuration register indexes
  localparam logic [2:0] REG_FOLLOW_DISTANCE     = 3'd0;
  localparam logic [2:0] REG_VELOCITY_GAIN       = 3'd1;
  localparam logic [2:0] REG_STEERING_GAIN       = 3'd2;
  localparam logic [2:0] REG_VELOCITY_MAX        = 3'd3;
  localparam logic [2:0] REG_STEERING_MAX        = 3'd4;
  localparam logic [2:0] REG_VELOCITY_RISE_LIMIT = 3'd5;
  localparam logic [2:0] REG_VELOCITY_FALL_LIMIT = 3'd6;
  localparam logic [2:0] REG_STEERING_STEP_LIMIT = 3'd7;

  // Reset values
  localparam logic [14:0] RST_FOLLOW_DISTANCE     = 15'd256;
  localparam logic [15:0] RST_VELOCITY_GAIN       = 16'd1556;
  localparam logic [15:0] RST_STEERING_GAIN       = 16'd3828;
  localparam logic [14:0] RST_VELOCITY_MAX        = 15'd384;
  localparam logic [14:0] RST_STEERING_MAX        = 15'd154;
  localparam logic [14:0] RST_VELOCITY_RISE_LIMIT = 15'd384;
  localparam logic [14:0] RST_VELOCITY_FALL_LIMIT = 15'd256;
  localparam logic [14:0] RST_STEERING_STEP_LIMIT = 15'd26;

  // Fixed search turn, 0.5 rad/s in Q8.8
  localparam logic signed [15:0] SEARCH_TURN = 16'sd128;

  typedef struct packed {
    logic [14:0] follow_distance;
    logic [15:0] velocity_gain;
    logic [15:0] steering_gain;
    logic [14:0] velocity_max;
    logic [14:0] steering_max;
    logic [14:0] velocity_rise_limit;
    logic [14:0] velocity_fall_limit;
    logic [14:0] steering_step_limit;
  } ftsc_cfg_t;

  typedef struct packed {
    logic signed [15:0] velocity;
    logic signed [15:0] steering;
    logic signed [15:0] linear;
  } ftsc_law_t;

endpackage

@@ sv/ftsc_law.sv @@
module ftsc_law
  import ftsc_pkg::*;
(
  input  ftsc_cfg_t          cfg,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] last_velocity,
  input  logic signed [15:0] last_steering,
  output ftsc_law_t          law
);

  logic signed [16:0] dx;
  logic signed [33:0] prod_v;
  logic signed [33:0] prod_s;
  logic signed [33:0] rnd_v;
  logic signed [33:0] rnd_s;
  logic signed [21:0] vel_raw;
  logic signed [21:0] str_raw;
  logic signed [21:0] vel_lo;
  logic signed [21:0] vel_hi;
  logic signed [21:0] str_lo;
  logic signed [21:0] str_hi;
  logic signed [21:0] vel_slew;
  logic signed [21:0] str_slew;
  logic signed [21:0] vel_max;
  logic signed [21:0] str_max;
  logic signed [21:0] vel_c;
  logic signed [21:0] str_c;
  logic [17:0]        vel_x5;

  // error * gain, Q8.8 * Q4.12 -> Q8.8 with round half up
  assign dx     = $signed({target_x[15], target_x}) - $signed({2'b00, cfg.follow_distance});
  assign prod_v = $signed({{17{dx[16]}}, dx}) * $signed({18'd0, cfg.velocity_gain});
  assign prod_s = $signed({{18{target_y[15]}}, target_y}) * $signed({18'd0, cfg.steering_gain});
  assign rnd_v  = prod_v + 34'sd2048;
  assign rnd_s  = prod_s + 34'sd2048;
  assign vel_raw = rnd_v[33:12];
  assign str_raw = rnd_s[33:12];

  assign vel_lo = $signed({{6{last_velocity[15]}}, last_velocity})
                - $signed({7'd0, cfg.velocity_fall_limit});
  assign vel_hi = $signed({{6{last_velocity[15]}}, last_velocity})
                + $signed({7'd0, cfg.velocity_rise_limit});
  assign str_lo = $signed({{6{last_steering[15]}}, last_steering})
                - $signed({7'd0, cfg.steering_step_limit});
  assign str_hi = $signed({{6{last_steering[15]}}, last_steering})
                + $signed({7'd0, cfg.steering_step_limit});
  assign vel_max = $signed({7'd0, cfg.velocity_max});
  assign str_max = $signed({7'd0, cfg.steering_max});

  always_comb begin
    // slew limit, then range clamp
    priority if (vel_raw > vel_hi) begin
      vel_slew = vel_hi;
    end else if (vel_raw < vel_lo) begin
      vel_slew = vel_lo;
    end else begin
      vel_slew = vel_raw;
    end
    priority if (vel_slew > vel_max) begin
      vel_c = vel_max;
    end else if (vel_slew < 22'sd0) begin
      vel_c = 22'sd0;
    end else begin
      vel_c = vel_slew;
    end

    priority if (str_raw > str_hi) begin
      str_slew = str_hi;
    end else if (str_raw < str_lo) begin
      str_slew = str_lo;
    end else begin
      str_slew = str_raw;
    end
    priority if (str_slew > str_max) begin
      str_c = str_max;
    end else if (str_slew < -str_max) begin
      str_c = -str_max;
    end else begin
      str_c = str_slew;
    end
  end

  // 2.5 * v, round half up; v is in [0, 32767]
  assign vel_x5 = {1'b0, vel_c[14:0], 2'b00} + {3'd0, vel_c[14:0]} + 18'd1;

  always_comb begin
    law.velocity = vel_c[15:0];
    law.steering = str_c[15:0];
    if (vel_x5[17:16] != 2'b00) begin
      law.linear = 16'sh7FFF;
    end else begin
      law.linear = $signed({1'b0, vel_x5[15:1]});
    end
  end

endmodule

@@ sv/follow_target_speed_steer_control.sv @@
// Person-following speed and steering controller, Q8.8 fixed point. Send
// op 0 with the first and last cluster points of a detected target, op 1 for
// an empty detection, op 2 for a reference point and op 3 as the control
// tick. Only a tick that arrives after a target or reference event produces
// a result transaction: either a proportional velocity/steering command
// (slew-limited per tick, then clamped) or, when no target is seen, the fixed
// search turn with out_searching set. Throughput is one transaction per
// cycle while the result channel is not stalled; an accepted input passes
// through the input register, then the single-pass control law into the
// result register, which raises out_valid.
// Configuration writes take effect on the next cycle and are expected only
// while the block is idle.
module follow_target_speed_steer_control
  import ftsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_last_x,
  input  logic signed [15:0] in_last_y,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_linear_command,
  output logic signed [15:0] out_turn_command,
  output logic               out_searching
);

  ftsc_cfg_t cfg_r;

  // input register stage; the midpoint is folded in ahead of it
  logic               s1_valid_r;
  ftsc_op_t           s1_op_r;
  logic signed [15:0] s1_mid_x_r;
  logic signed [15:0] s1_mid_y_r;
  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;

  // controller state
  logic signed [15:0] target_x_r;
  logic signed [15:0] target_y_r;
  logic               target_seen_r;
  logic               data_valid_r;
  logic signed [15:0] last_velocity_r;
  logic signed [15:0] last_steering_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_linear_r;
  logic signed [15:0] out_turn_r;
  logic               out_searching_r;

  logic      out_free;
  logic      s1_adv;
  logic      in_fire;
  logic      emit;
  ftsc_law_t law;

  // ---------------------------------------------------------------------
  // Handshake: the result register frees up when empty or being taken.
  // The input stage moves on whenever the result register is free, even
  // for events that produce no result, so state updates in arrival order.
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign emit     = s1_adv && (s1_op_r == OP_TICK) && data_valid_r;

  // floor((a + b) / 2): drop the low bit of the 17-bit sum
  assign sum_x = $signed({in_first_x[15], in_first_x}) + $signed({in_last_x[15], in_last_x});
  assign sum_y = $signed({in_first_y[15], in_first_y}) + $signed({in_last_y[15], in_last_y});

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.follow_distance     <= RST_FOLLOW_DISTANCE;
      cfg_r.velocity_gain       <= RST_VELOCITY_GAIN;
      cfg_r.steering_gain       <= RST_STEERING_GAIN;
      cfg_r.velocity_max        <= RST_VELOCITY_MAX;
      cfg_r.steering_max        <= RST_STEERING_MAX;
      cfg_r.velocity_rise_limit <= RST_VELOCITY_RISE_LIMIT;
      cfg_r.velocity_fall_limit <= RST_VELOCITY_FALL_LIMIT;
      cfg_r.steering_step_limit <= RST_STEERING_STEP_LIMIT;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FOLLOW_DISTANCE:     cfg_r.follow_distance     <= cfg_data[14:0];
        REG_VELOCITY_GAIN:       cfg_r.velocity_gain       <= cfg_data;
        REG_STEERING_GAIN:       cfg_r.steering_gain       <= cfg_data;
        REG_VELOCITY_MAX:        cfg_r.velocity_max        <= cfg_data[14:0];
        REG_STEERING_MAX:        cfg_r.steering_max        <= cfg_data[14:0];
        REG_VELOCITY_RISE_LIMIT: cfg_r.velocity_rise_limit <= cfg_data[14:0];
        REG_VELOCITY_FALL_LIMIT: cfg_r.velocity_fall_limit <= cfg_data[14:0];
        REG_STEERING_STEP_LIMIT: cfg_r.steering_step_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= ftsc_op_t'(in_op);
      s1_mid_x_r <= sum_x[16:1];
      s1_mid_y_r <= sum_y[16:1];
    end
  end

  // ---------------------------------------------------------------------
  // Control law: proportional gain, slew limit, clamp, 2.5x scale
  // ---------------------------------------------------------------------
  ftsc_law u_law (
    .cfg           (cfg_r),
    .target_x      (target_x_r),
    .target_y      (target_y_r),
    .last_velocity (last_velocity_r),
    .last_steering (last_steering_r),
    .law           (law)
  );

  // ---------------------------------------------------------------------
  // Controller state, updated as each transaction leaves the input stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r      <= '0;
      target_y_r      <= '0;
      target_seen_r   <= 1'b0;
      data_valid_r    <= 1'b0;
      last_velocity_r <= '0;
      last_steering_r <= '0;
    end else if (s1_adv) begin
      unique case (s1_op_r)
        OP_TARGET: begin
          target_x_r    <= s1_mid_x_r;
          target_y_r    <= s1_mid_y_r;
          target_seen_r <= 1'b1;
          data_valid_r  <= 1'b1;
        end
        OP_EMPTY: begin
          target_seen_r <= 1'b0;
        end
        OP_REF: begin
          data_valid_r <= 1'b1;
        end
        OP_TICK: begin
          // last values move only on a real command, not on a search turn
          if (data_valid_r && target_seen_r) begin
            last_velocity_r <= law.velocity;
            last_steering_r <= law.steering;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register; holds while stalled
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (target_seen_r) begin
        out_linear_r    <= law.linear;
        out_turn_r      <= law.steering;
        out_searching_r <= 1'b0;
      end else begin
        out_linear_r    <= '0;
        out_turn_r      <= SEARCH_TURN;
        out_searching_r <= 1'b1;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_linear_command = out_linear_r;
  assign out_turn_command   = out_turn_r;
  assign out_searching      = out_searching_r;

endmodule

@@ sv/ftsc_checker.sv @@
module ftsc_checker
  import ftsc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_linear_command,
  input logic signed [15:0] out_turn_command,
  input logic               out_searching
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_command)
      && $stable(out_turn_command) && $stable(out_searching))
    else $error("result changed while stalled");

  // back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // search result is the fixed turn
  a_search_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_searching |-> out_linear_command == 16'sd0
      && out_turn_command == SEARCH_TURN)
    else $error("bad search result");

  // velocity is clamped at zero, so the linear command never goes negative
  a_linear_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_searching |-> !out_linear_command[15])
    else $error("negative linear command");

endmodule

bind follow_target_speed_steer_control ftsc_checker u_ftsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_linear_command (out_linear_command),
  .out_turn_command   (out_turn_command),
  .out_searching      (out_searching)
);
